/* hw/rtl/tone_curve_lut_mapper_core_defines.svh */
// Shared assertion macros for the tone curve block.
`ifndef TONE_CURVE_LUT_MAPPER_CORE_DEFINES_SVH
`define TONE_CURVE_LUT_MAPPER_CORE_DEFINES_SVH

// Checked only while the block is out of reset.
`define TCLM_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TCLM_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/tclm_pkg.sv */
package tclm_pkg;

  localparam int unsigned SMP_W    = 16;
  localparam int unsigned CHAN_W   = 17;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned NUM_PTS  = 8;
  localparam int unsigned CFG_W    = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned T_W      = 17;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 72;
  localparam logic [SMP_W-1:0] ONE_Q15 = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_COUNT = 3'd0,
    CFG_PAIR0       = 3'd1,
    CFG_PAIR1       = 3'd2,
    CFG_PAIR2       = 3'd3,
    CFG_PAIR3       = 3'd4
  } cfg_idx_e;

  localparam logic FUNC_PIXEL   = 1'b0;
  localparam logic FUNC_REBUILD = 1'b1;

  typedef struct packed {
    logic       init_wr;
    logic       item_load;
    logic       ramp_clear;
    logic       ramp_step;
    logic       seg_load;
    logic       div_start;
    logic       mul_rb;
    logic       tbl_wr;
    logic       px_idx;
    logic       px_rd;
    logic       px_mul;
    logic       px_acc;
    logic       out_load;
    logic [1:0] chan;
  } cmd_t;

  typedef struct packed {
    logic last_entry;
    logic div_done;
  } sts_t;

endpackage

/* hw/rtl/tclm_div.sv */
module tclm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tclm_pkg::SMP_W-1:0] num,
  input  logic [tclm_pkg::SMP_W-1:0] den,
  output logic                      done,
  output logic [tclm_pkg::T_W-1:0]   quo
);
  import tclm_pkg::*;

  // Restoring division of num * 65536 by den, one quotient bit a cycle.
  logic [SMP_W:0]   rem_r, rem_nxt, sh;
  logic [T_W-1:0]   quo_r, quo_nxt;
  logic [SMP_W-1:0] den_r;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r, done_nxt;
  logic             ge;

  always_comb begin
    sh       = (cnt_r == 5'd0) ? rem_r : {rem_r[SMP_W-1:0], 1'b0};
    ge       = sh >= {1'b0, den_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = {1'b0, num};
      quo_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? (sh - {1'b0, den_r}) : sh;
      quo_nxt = {quo_r[T_W-2:0], ge};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(T_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* hw/rtl/tclm_dp.sv */
module tclm_dp #(
  parameter int unsigned TABLE_SIZE = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tclm_pkg::cmd_t                  cmd,
  output tclm_pkg::sts_t                  sts,
  input  logic                            cfg_we,
  input  logic [tclm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tclm_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_func,
  input  logic [tclm_pkg::CNT_W-1:0]      in_channel_count,
  input  logic signed [tclm_pkg::CHAN_W-1:0] in_chan0,
  input  logic signed [tclm_pkg::CHAN_W-1:0] in_chan1,
  input  logic signed [tclm_pkg::CHAN_W-1:0] in_chan2,
  input  logic signed [tclm_pkg::CHAN_W-1:0] in_chan3,
  output logic signed [tclm_pkg::CHAN_W-1:0] out_chan0,
  output logic signed [tclm_pkg::CHAN_W-1:0] out_chan1,
  output logic signed [tclm_pkg::CHAN_W-1:0] out_chan2,
  output logic signed [tclm_pkg::CHAN_W-1:0] out_chan3
);
  import tclm_pkg::*;

  localparam int unsigned AW  = $clog2(TABLE_SIZE);
  localparam int unsigned TM1 = TABLE_SIZE - 1;
  localparam int unsigned RQ  = 32768 / TM1;
  localparam int unsigned RR  = 32768 % TM1;
  localparam int unsigned PW  = SMP_W + AW;

  // Configuration registers.
  logic [3:0]       pcount_r;
  logic [CFG_W-1:0] pair_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r  <= 4'd2;
      pair_r[0] <= 64'h8000800000000000;
      pair_r[1] <= '0;
      pair_r[2] <= '0;
      pair_r[3] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POINT_COUNT: pcount_r  <= cfg_wdata[3:0];
        CFG_PAIR0:       pair_r[0] <= cfg_wdata;
        CFG_PAIR1:       pair_r[1] <= cfg_wdata;
        CFG_PAIR2:       pair_r[2] <= cfg_wdata;
        CFG_PAIR3:       pair_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Latched item.
  logic                     func_r;
  logic [CNT_W-1:0]         ccount_r;
  logic signed [CHAN_W-1:0] ch_r [4];

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      func_r   <= in_func;
      ccount_r <= in_channel_count;
      ch_r[0]  <= in_chan0;
      ch_r[1]  <= in_chan1;
      ch_r[2]  <= in_chan2;
      ch_r[3]  <= in_chan3;
    end
  end

  // Table position counter and ramp position floor(i*32768/(N-1)).
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    frac_r, frac_nxt;
  logic [SMP_W-1:0] x_r, x_nxt;
  logic [AW:0]      frac_sum;
  logic             carry;

  always_comb begin
    frac_sum = {1'b0, frac_r} + (AW+1)'(RR);
    carry    = frac_sum >= (AW+1)'(TM1);
    idx_nxt  = idx_r;
    frac_nxt = frac_r;
    x_nxt    = x_r;
    if (cmd.ramp_clear) begin
      idx_nxt  = '0;
      frac_nxt = '0;
      x_nxt    = '0;
    end else if (cmd.ramp_step) begin
      idx_nxt  = idx_r + AW'(1);
      frac_nxt = carry ? AW'(frac_sum - (AW+1)'(TM1)) : frac_sum[AW-1:0];
      x_nxt    = x_r + SMP_W'(RQ) + SMP_W'(carry);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      frac_r <= '0;
      x_r    <= '0;
    end else begin
      idx_r  <= idx_nxt;
      frac_r <= frac_nxt;
      x_r    <= x_nxt;
    end
  end

  assign sts.last_entry = (idx_r == AW'(TM1));

  // Curve points with clamping and the identity curve for zero points.
  logic [SMP_W-1:0] px [NUM_PTS];
  logic [SMP_W-1:0] py [NUM_PTS];
  logic [3:0]       n_eff;
  logic             ident;
  logic [SMP_W-1:0] raw_x, raw_y;

  always_comb begin
    ident = (pcount_r == 4'd0);
    n_eff = ident ? 4'd2 : ((pcount_r > 4'd8) ? 4'd8 : pcount_r);
    for (int k = 0; k < NUM_PTS; k++) begin
      raw_x = pair_r[k/2][(k%2)*32 +: SMP_W];
      raw_y = pair_r[k/2][(k%2)*32 + 16 +: SMP_W];
      px[k] = (raw_x > ONE_Q15) ? ONE_Q15 : raw_x;
      py[k] = (raw_y > ONE_Q15) ? ONE_Q15 : raw_y;
    end
    if (ident) begin
      px[0] = '0;
      py[0] = '0;
      px[1] = ONE_Q15;
      py[1] = ONE_Q15;
    end
  end

  // Segment selection for the current ramp position.
  logic [2:0]       last_k, seg_k;
  logic             seg_found, below, above;
  logic [SMP_W-1:0] sx0, sx1;

  always_comb begin
    last_k    = 3'(n_eff - 4'd1);
    below     = x_r <= px[0];
    above     = !(x_r < px[last_k]);
    seg_k     = 3'd1;
    seg_found = 1'b0;
    for (int k = 1; k < NUM_PTS; k++) begin
      if (!seg_found && (4'(k) < n_eff) && (x_r <= px[k])) begin
        seg_k     = 3'(k);
        seg_found = 1'b1;
      end
    end
    sx0 = px[seg_k - 3'd1];
    sx1 = px[seg_k];
  end

  logic [SMP_W-1:0] y0_r, y1_r, num_r, den_r;
  logic             tz_r;

  always_ff @(posedge clk) begin
    if (cmd.seg_load) begin
      priority if (below) begin
        y0_r <= py[0];
        y1_r <= py[0];
      end else if (above) begin
        y0_r <= py[last_k];
        y1_r <= py[last_k];
      end else begin
        y0_r <= py[seg_k - 3'd1];
        y1_r <= py[seg_k];
      end
      num_r <= (x_r > sx0) ? (x_r - sx0) : '0;
      den_r <= (sx1 > sx0) ? (sx1 - sx0) : '0;
      tz_r  <= below || above || !(sx1 > sx0) || !(x_r > sx0);
    end
  end

  logic [T_W-1:0] quo;

  tclm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (sts.div_done),
    .quo   (quo)
  );

  logic signed [SMP_W:0]       dy;
  logic signed [T_W:0]         t_s;
  logic signed [SMP_W+T_W+1:0] prod_rb_r;
  logic signed [SMP_W+T_W+1:0] y_full;

  assign dy     = $signed({1'b0, y1_r}) - $signed({1'b0, y0_r});
  assign t_s    = tz_r ? '0 : $signed({1'b0, quo});
  assign y_full = $signed({{(T_W+2){1'b0}}, y0_r}) + (prod_rb_r >>> 16);

  always_ff @(posedge clk) begin
    if (cmd.mul_rb) prod_rb_r <= dy * t_s;
  end

  // Pixel lookup.
  logic signed [CHAN_W-1:0] smp;
  logic [SMP_W-1:0]         d;
  logic [PW-1:0]            p;
  logic [AW:0]              pidx;
  logic                     plast;
  logic [AW-1:0]            addr_a_r, addr_b_r;
  logic [14:0]              f_r;

  always_comb begin
    smp   = ch_r[cmd.chan];
    if (smp < 0) d = '0;
    else if (smp > $signed({1'b0, ONE_Q15})) d = ONE_Q15;
    else d = smp[SMP_W-1:0];
    p     = PW'(d) * PW'(TM1);
    pidx  = p[PW-1:15];
    plast = pidx >= (AW+1)'(TM1);
  end

  always_ff @(posedge clk) begin
    if (cmd.px_idx) begin
      addr_a_r <= pidx[AW-1:0];
      addr_b_r <= plast ? AW'(TM1) : (pidx[AW-1:0] + AW'(1));
      f_r      <= plast ? '0 : p[14:0];
    end
  end

  logic [SMP_W-1:0] tbl [TABLE_SIZE];
  logic [SMP_W-1:0] rd_a_r, rd_b_r;

  always_ff @(posedge clk) begin
    if (cmd.init_wr) tbl[idx_r] <= x_r;
    else if (cmd.tbl_wr) tbl[idx_r] <= y_full[SMP_W-1:0];
    if (cmd.px_rd) begin
      rd_a_r <= tbl[addr_a_r];
      rd_b_r <= tbl[addr_b_r];
    end
  end

  logic signed [SMP_W:0]   diff;
  logic signed [2*SMP_W:0] prod_px_r;
  logic signed [2*SMP_W:0] mapped;
  logic [SMP_W-1:0]        res_r [3];

  assign diff   = $signed({1'b0, rd_b_r}) - $signed({1'b0, rd_a_r});
  assign mapped = $signed({{(SMP_W+1){1'b0}}, rd_a_r}) + (prod_px_r >>> 15);

  always_ff @(posedge clk) begin
    if (cmd.px_mul) prod_px_r <= diff * $signed({1'b0, f_r});
    if (cmd.px_acc) res_r[cmd.chan] <= mapped[SMP_W-1:0];
  end

  // Result register.
  logic [CNT_W-1:0]         c_eff;
  logic signed [CHAN_W-1:0] o_r [4];

  assign c_eff = (ccount_r > 3'd4) ? 3'd4 : ccount_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (func_r == FUNC_REBUILD) begin
        for (int c = 0; c < 4; c++) o_r[c] <= '0;
      end else begin
        for (int c = 0; c < 3; c++) begin
          o_r[c] <= (c_eff > 3'(c)) ? $signed({1'b0, res_r[c]}) : '0;
        end
        o_r[3] <= (c_eff > 3'd3) ? ch_r[3] : '0;
      end
    end
  end

  assign out_chan0 = o_r[0];
  assign out_chan1 = o_r[1];
  assign out_chan2 = o_r[2];
  assign out_chan3 = o_r[3];

endmodule

/* hw/rtl/tclm_ctrl.sv */
module tclm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           in_tuser,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output tclm_pkg::cmd_t cmd,
  input  tclm_pkg::sts_t sts
);
  import tclm_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RB_SEG, S_RB_START, S_RB_DIV, S_RB_MUL, S_RB_WR,
    S_PX_IDX, S_PX_RD, S_PX_MUL, S_PX_ACC, S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] chan_r, chan_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, out_free;

  assign accept   = (state_r == S_IDLE) && in_tvalid;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    cmd           = '0;
    cmd.chan      = chan_r;
    state_nxt     = state_r;
    chan_nxt      = chan_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    unique case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.last_entry) state_nxt = S_IDLE;
        else cmd.ramp_step = 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.item_load  = 1'b1;
          cmd.ramp_clear = 1'b1;
          chan_nxt       = '0;
          state_nxt      = (in_tuser == FUNC_REBUILD) ? S_RB_SEG : S_PX_IDX;
        end
      end
      S_RB_SEG: begin
        cmd.seg_load = 1'b1;
        state_nxt    = S_RB_START;
      end
      S_RB_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_RB_DIV;
      end
      S_RB_DIV: begin
        if (sts.div_done) state_nxt = S_RB_MUL;
      end
      S_RB_MUL: begin
        cmd.mul_rb = 1'b1;
        state_nxt  = S_RB_WR;
      end
      S_RB_WR: begin
        cmd.tbl_wr = 1'b1;
        if (sts.last_entry) begin
          state_nxt = S_DONE;
        end else begin
          cmd.ramp_step = 1'b1;
          state_nxt     = S_RB_SEG;
        end
      end
      S_PX_IDX: begin
        cmd.px_idx = 1'b1;
        state_nxt  = S_PX_RD;
      end
      S_PX_RD: begin
        cmd.px_rd = 1'b1;
        state_nxt = S_PX_MUL;
      end
      S_PX_MUL: begin
        cmd.px_mul = 1'b1;
        state_nxt  = S_PX_ACC;
      end
      S_PX_ACC: begin
        cmd.px_acc = 1'b1;
        if (chan_r == 2'd2) begin
          state_nxt = S_DONE;
        end else begin
          chan_nxt  = chan_r + 2'd1;
          state_nxt = S_PX_IDX;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      chan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chan_r      <= chan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

/* hw/rtl/tone_curve_lut_mapper_core.sv */
// Applies a piecewise-linear tone curve of up to eight points to pixels through a table of
// TABLE_SIZE entries. A pixel request clamps each of its first three channels to 0..1.0,
// interpolates between two adjacent table entries and returns one result; channel 3 is
// passed through. Channels at or beyond the request's channel count return zero. The three
// channels are handled in turn, each through the index, table read, multiply and accumulate
// steps, since there is a single two-port table read and one multiplier; a new pixel request
// is taken only once the previous result is loaded. A rebuild request recomputes the table
// from the configured points and returns an all-zero result; each entry waits on the serial
// divider that forms its interpolation fraction. After reset the table is filled with the
// identity ramp, during which no request is taken. The next request is accepted while a
// result still waits on the output. Point registers take effect only at the next rebuild.
module tone_curve_lut_mapper_core #(
  parameter int unsigned TABLE_SIZE = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // channel_count[2:0], in_chan0, in_chan1, in_chan2, in_chan3, zero pad
  input  logic [tclm_pkg::IN_DATA_W-1:0]      in_tdata,
  // func
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_chan0, out_chan1, out_chan2, out_chan3, zero pad
  output logic [tclm_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [tclm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tclm_pkg::CFG_W-1:0]          cfg_wdata
);
  import tclm_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic signed [CHAN_W-1:0] oc0, oc1, oc2, oc3;

  tclm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  tclm_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_func          (in_tuser),
    .in_channel_count (in_tdata[2:0]),
    .in_chan0         (in_tdata[19:3]),
    .in_chan1         (in_tdata[36:20]),
    .in_chan2         (in_tdata[53:37]),
    .in_chan3         (in_tdata[70:54]),
    .out_chan0        (oc0),
    .out_chan1        (oc1),
    .out_chan2        (oc2),
    .out_chan3        (oc3)
  );

  assign out_tdata = {4'b0, oc3, oc2, oc1, oc0};

endmodule

/* hw/rtl/tclm_checker.sv */
`include "tone_curve_lut_mapper_core_defines.svh"

module tclm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [tclm_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tclm_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tclm_pkg::*;

  `TCLM_ASSERT_RUN(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")
  `TCLM_ASSERT_RUN(a_in_hold, in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser), "request changed while waiting")
  `TCLM_ASSERT_RUN(a_one_at_a_time, in_tvalid && in_tready |=> !in_tready, "second request taken while busy")
  `TCLM_ASSERT_ALL(a_reset_quiet, !rst_n |=> !out_tvalid, "result shown right after reset")

endmodule

bind tone_curve_lut_mapper_core tclm_checker u_tclm_checker (.*);
